// ----- hdl/aav_pkg.sv -----
// Package with shared constants, tables and types for the axis-angle vector rotator.
package aav_pkg;

    localparam int TrigIterDefault = 16;
    localparam int AtanSteps       = 24;

    localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
    localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
    localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;
    localparam logic signed [33:0] Q30Gain   = 34'sd652032874;

    localparam logic signed [35:0] AtanQ30 [0:AtanSteps-1] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
        36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
        36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
        36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
        36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
        36'sd1024,      36'sd512,       36'sd256,       36'sd128
    };

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_carry;

endpackage

// ----- hdl/aav_cordic.sv -----
// Pipelined angle reduction and rotation-mode CORDIC giving cosine and sine in Q24.
module aav_cordic #(
    parameter int Steps = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [15:0]  i_angle,
    input  aav_pkg::t_carry     i_carry,
    output logic                o_valid,
    output logic signed [26:0]  o_cos,
    output logic signed [26:0]  o_sin,
    output aav_pkg::t_carry     o_carry
);
    import aav_pkg::*;

    logic                r_v1;
    logic signed [35:0]  r_z1;
    t_carry              r_c1;
    logic signed [35:0]  n_z1;
    logic signed [35:0]  w_ang;

    logic                r_vld  [0:Steps];
    logic                r_flip [0:Steps];
    logic signed [33:0]  r_x    [0:Steps];
    logic signed [33:0]  r_y    [0:Steps];
    logic signed [35:0]  r_z    [0:Steps];
    t_carry              r_car  [0:Steps];

    logic signed [35:0]  n_z0;
    logic                n_flip0;
    logic signed [33:0]  w_xf;
    logic signed [33:0]  w_yf;
    logic signed [33:0]  w_xr;
    logic signed [33:0]  w_yr;

    assign w_ang = $signed({{3{i_angle[15]}}, i_angle, 17'b0});

    always_comb begin
        if (w_ang > Q30Pi) begin
            n_z1 = w_ang - Q30TwoPi;
        end else if (w_ang <= -Q30Pi) begin
            n_z1 = w_ang + Q30TwoPi;
        end else begin
            n_z1 = w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_z1 <= n_z1;
        r_c1 <= i_carry;
    end

    always_comb begin
        if (r_z1 > Q30HalfPi) begin
            n_z0    = r_z1 - Q30Pi;
            n_flip0 = 1'b1;
        end else if (r_z1 < -Q30HalfPi) begin
            n_z0    = r_z1 + Q30Pi;
            n_flip0 = 1'b1;
        end else begin
            n_z0    = r_z1;
            n_flip0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_v1;
        end
        r_flip[0] <= n_flip0;
        r_x[0]    <= Q30Gain;
        r_y[0]    <= '0;
        r_z[0]    <= n_z0;
        r_car[0]  <= r_c1;
    end

    for (genvar i = 0; i < Steps; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_flip[i+1] <= r_flip[i];
            r_car[i+1]  <= r_car[i];
            if (!r_z[i][35]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - AtanQ30[i];
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + AtanQ30[i];
            end
        end
    end

    assign w_xf = r_flip[Steps] ? -r_x[Steps] : r_x[Steps];
    assign w_yf = r_flip[Steps] ? -r_y[Steps] : r_y[Steps];
    assign w_xr = (w_xf + 34'sd32) >>> 6;
    assign w_yr = (w_yf + 34'sd32) >>> 6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[Steps];
        end
        o_cos   <= w_xr[26:0];
        o_sin   <= w_yr[26:0];
        o_carry <= r_car[Steps];
    end

endmodule

// ----- hdl/axis_angle_vector_rotate_top.sv -----
// Top level of the axis-angle vector rotator: trig pipeline, matrix build and apply.
// Start flows through angle wrap, quadrant fold, CORDIC steps, matrix build and apply.
// One word per cycle (busy stays low); one CORDIC stage per iteration, up to AtanSteps.
// Reset is synchronous and active low; it clears only the valid bits of the pipeline.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module axis_angle_vector_rotate_top #(
    parameter int TRIG_ITERATIONS = aav_pkg::TrigIterDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_angle,
    input  logic signed [15:0]  i_axis_x,
    input  logic signed [15:0]  i_axis_y,
    input  logic signed [15:0]  i_axis_z,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_vec_z,
    output logic                o_valid,
    output logic signed [31:0]  o_rot_x,
    output logic signed [31:0]  o_rot_y,
    output logic signed [31:0]  o_rot_z,
    output logic                o_saturated
);
    import aav_pkg::*;

    localparam int Steps = (TRIG_ITERATIONS > AtanSteps) ? AtanSteps : TRIG_ITERATIONS;
    localparam int Lat   = Steps + 9;

    t_carry              w_cin;
    logic                w_cv;
    logic signed [26:0]  w_cos;
    logic signed [26:0]  w_sin;
    t_carry              w_car;

    logic                r_va;
    logic signed [27:0]  r_t;
    logic signed [26:0]  r_ca;
    logic signed [26:0]  r_sa;
    logic signed [31:0]  r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    t_carry              r_cara;

    logic                r_vb;
    logic signed [59:0]  r_qxx, r_qyy, r_qzz, r_qxy, r_qxz, r_qyz;
    logic signed [42:0]  r_sx, r_sy, r_sz;
    logic signed [26:0]  r_cb;
    t_carry              r_carb;

    logic                r_vc;
    logic signed [31:0]  r_m [0:8];
    t_carry              r_carc;
    logic signed [59:0]  w_rxx, w_ryy, w_rzz, w_rxy, w_rxz, w_ryz;
    logic signed [42:0]  w_rsx, w_rsy, w_rsz;
    logic signed [31:0]  w_cx;

    logic                r_vd;
    logic signed [63:0]  r_p [0:8];

    logic                r_ve;
    logic signed [63:0]  r_sum [0:2];
    logic signed [63:0]  w_s0, w_s1, w_s2;

    logic                n_sat;
    logic signed [31:0]  n_rot [0:2];

    assign busy  = 1'b0;
    assign w_cin = '{ax: i_axis_x, ay: i_axis_y, az: i_axis_z,
                     vx: i_vec_x, vy: i_vec_y, vz: i_vec_z};

    aav_cordic #(
        .Steps (Steps)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_angle (i_angle),
        .i_carry (w_cin),
        .o_valid (w_cv),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_carry (w_car)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_va <= w_cv;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
        r_t    <= 28'sd16777216 - 28'(w_cos);
        r_ca   <= w_cos;
        r_sa   <= w_sin;
        r_pxx  <= w_car.ax * w_car.ax;
        r_pyy  <= w_car.ay * w_car.ay;
        r_pzz  <= w_car.az * w_car.az;
        r_pxy  <= w_car.ax * w_car.ay;
        r_pxz  <= w_car.ax * w_car.az;
        r_pyz  <= w_car.ay * w_car.az;
        r_cara <= w_car;

        r_qxx  <= r_t * r_pxx;
        r_qyy  <= r_t * r_pyy;
        r_qzz  <= r_t * r_pzz;
        r_qxy  <= r_t * r_pxy;
        r_qxz  <= r_t * r_pxz;
        r_qyz  <= r_t * r_pyz;
        r_sx   <= r_cara.ax * r_sa;
        r_sy   <= r_cara.ay * r_sa;
        r_sz   <= r_cara.az * r_sa;
        r_cb   <= r_ca;
        r_carb <= r_cara;
    end

    always_comb begin
        w_rxx = (r_qxx + 60'sh8000000) >>> 28;
        w_ryy = (r_qyy + 60'sh8000000) >>> 28;
        w_rzz = (r_qzz + 60'sh8000000) >>> 28;
        w_rxy = (r_qxy + 60'sh8000000) >>> 28;
        w_rxz = (r_qxz + 60'sh8000000) >>> 28;
        w_ryz = (r_qyz + 60'sh8000000) >>> 28;
        w_rsx = (r_sx + 43'sd8192) >>> 14;
        w_rsy = (r_sy + 43'sd8192) >>> 14;
        w_rsz = (r_sz + 43'sd8192) >>> 14;
        w_cx  = 32'(r_cb);
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= w_cx + w_rxx[31:0];
        r_m[1] <= w_rxy[31:0] - w_rsz[31:0];
        r_m[2] <= w_rxz[31:0] + w_rsy[31:0];
        r_m[3] <= w_rxy[31:0] + w_rsz[31:0];
        r_m[4] <= w_cx + w_ryy[31:0];
        r_m[5] <= w_ryz[31:0] - w_rsx[31:0];
        r_m[6] <= w_rxz[31:0] - w_rsy[31:0];
        r_m[7] <= w_ryz[31:0] + w_rsx[31:0];
        r_m[8] <= w_cx + w_rzz[31:0];
        r_carc <= r_carb;

        r_p[0] <= r_m[0] * r_carc.vx;
        r_p[1] <= r_m[1] * r_carc.vy;
        r_p[2] <= r_m[2] * r_carc.vz;
        r_p[3] <= r_m[3] * r_carc.vx;
        r_p[4] <= r_m[4] * r_carc.vy;
        r_p[5] <= r_m[5] * r_carc.vz;
        r_p[6] <= r_m[6] * r_carc.vx;
        r_p[7] <= r_m[7] * r_carc.vy;
        r_p[8] <= r_m[8] * r_carc.vz;
    end

    assign w_s0 = r_p[0] + r_p[1] + r_p[2] + 64'sd8388608;
    assign w_s1 = r_p[3] + r_p[4] + r_p[5] + 64'sd8388608;
    assign w_s2 = r_p[6] + r_p[7] + r_p[8] + 64'sd8388608;

    always_ff @(posedge i_clk) begin
        r_sum[0] <= w_s0 >>> 24;
        r_sum[1] <= w_s1 >>> 24;
        r_sum[2] <= w_s2 >>> 24;
    end

    always_comb begin
        n_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_sum[k] > 64'sd2147483647) begin
                n_rot[k] = 32'sh7FFFFFFF;
                n_sat    = 1'b1;
            end else if (r_sum[k] < -64'sd2147483648) begin
                n_rot[k] = 32'sh80000000;
                n_sat    = 1'b1;
            end else begin
                n_rot[k] = r_sum[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_ve;
        end
        o_rot_x     <= n_rot[0];
        o_rot_y     <= n_rot[1];
        o_rot_z     <= n_rot[2];
        o_saturated <= n_sat;
    end

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, Lat))
        else $error("result strobe without a matching start");

    a_rst : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_rot_x == 32'sh7FFFFFFF || o_rot_x == 32'sh80000000 ||
             o_rot_y == 32'sh7FFFFFFF || o_rot_y == 32'sh80000000 ||
             o_rot_z == 32'sh7FFFFFFF || o_rot_z == 32'sh80000000))
        else $error("saturated flag without a clipped component");

endmodule

// ----- bench/aav_checker.sv -----
// Checker for the axis-angle vector rotator: predicts each rotated word and compares it.
module aav_checker #(
    parameter int TRIG_ITERATIONS = aav_pkg::TrigIterDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_angle,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic               o_valid,
    input  logic signed [31:0] o_rot_x,
    input  logic signed [31:0] o_rot_y,
    input  logic signed [31:0] o_rot_z,
    input  logic               o_saturated,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import aav_pkg::*;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic               sat;
    } t_rotated;

    t_rotated rotated_q[$];

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_rotated rotate_vector(
        logic signed [15:0] ang16, logic signed [15:0] ax16, logic signed [15:0] ay16,
        logic signed [15:0] az16, logic signed [31:0] vx32, logic signed [31:0] vy32,
        logic signed [31:0] vz32);
        longint x, y, z, dx, dy, c, s, t, ax, ay, az, vx, vy, vz;
        longint txy, txz, tyz, sx, sy, sz;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        int steps;
        logic flip;
        logic sat;
        t_rotated r;
        x = Q30Gain;
        y = 0;
        z = longint'(ang16) * 131072;
        flip = 1'b0;
        sat = 1'b0;
        steps = (TRIG_ITERATIONS > AtanSteps) ? AtanSteps : TRIG_ITERATIONS;
        if (z > Q30Pi) z -= Q30TwoPi;
        else if (z <= -Q30Pi) z += Q30TwoPi;
        if (z > Q30HalfPi) begin
            z -= Q30Pi;
            flip = 1'b1;
        end else if (z < -Q30HalfPi) begin
            z += Q30Pi;
            flip = 1'b1;
        end
        for (int i = 0; i < steps; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= AtanQ30[i];
            end else begin
                x += dx;
                y -= dy;
                z += AtanQ30[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_shift(x, 6);
        s = round_shift(y, 6);
        t = 64'sd16777216 - c;
        ax = ax16; ay = ay16; az = az16;
        vx = vx32; vy = vy32; vz = vz32;
        txy = round_shift(t * (ax * ay), 28);
        txz = round_shift(t * (ax * az), 28);
        tyz = round_shift(t * (ay * az), 28);
        sx = round_shift(ax * s, 14);
        sy = round_shift(ay * s, 14);
        sz = round_shift(az * s, 14);
        m00 = c + round_shift(t * (ax * ax), 28);
        m01 = txy - sz;
        m02 = txz + sy;
        m10 = txy + sz;
        m11 = c + round_shift(t * (ay * ay), 28);
        m12 = tyz - sx;
        m20 = txz - sy;
        m21 = tyz + sx;
        m22 = c + round_shift(t * (az * az), 28);
        r.rx = clamp32(round_shift(m00 * vx + m01 * vy + m02 * vz, 24), sat);
        r.ry = clamp32(round_shift(m10 * vx + m11 * vy + m12 * vz, 24), sat);
        r.rz = clamp32(round_shift(m20 * vx + m21 * vy + m22 * vz, 24), sat);
        r.sat = sat;
        return r;
    endfunction

    initial fail_count = 0;
    assign pending = rotated_q.size();

    always @(posedge i_clk) begin
        t_rotated want;
        if (i_rst_n && o_valid) begin
            if (rotated_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected word: %0d %0d %0d %0b",
                    o_rot_x, o_rot_y, o_rot_z, o_saturated);
            end else begin
                want = rotated_q.pop_front();
                if (want.rx !== o_rot_x || want.ry !== o_rot_y || want.rz !== o_rot_z
                        || want.sat !== o_saturated) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                            want.rx, want.ry, want.rz, want.sat,
                            o_rot_x, o_rot_y, o_rot_z, o_saturated);
                end
            end
        end
        if (i_rst_n && start && !busy)
            rotated_q.push_back(rotate_vector(i_angle, i_axis_x, i_axis_y, i_axis_z,
                i_vec_x, i_vec_y, i_vec_z));
    end
endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the axis-angle vector rotator: stimulus, clock, reset and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_angle = '0;
    logic signed [15:0] i_axis_x = '0;
    logic signed [15:0] i_axis_y = '0;
    logic signed [15:0] i_axis_z = '0;
    logic signed [31:0] i_vec_x = '0;
    logic signed [31:0] i_vec_y = '0;
    logic signed [31:0] i_vec_z = '0;
    logic               o_valid;
    logic signed [31:0] o_rot_x;
    logic signed [31:0] o_rot_y;
    logic signed [31:0] o_rot_z;
    logic               o_saturated;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    axis_angle_vector_rotate_top uut (.*);
    aav_checker chk (.*);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(logic signed [15:0] ang, logic signed [15:0] ax,
            logic signed [15:0] ay, logic signed [15:0] az, logic signed [31:0] vx,
            logic signed [31:0] vy, logic signed [31:0] vz, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_angle <= ang;
        i_axis_x <= ax;
        i_axis_y <= ay;
        i_axis_z <= az;
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sh8000;
            3: return 16'(32'($urandom));
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return 32'(int'($urandom_range(0, 20000000)) - 10000000);
        endcase
    endfunction

    initial begin
        logic signed [15:0] ax, ay, az;
        int gap;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_word(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sd65536, 32'sd65536, 32'sd0, 0);
        send_word(16'sd12868, 16'sd0, 16'sd0, 16'sd16384, 32'sd65536, 32'sd0, 32'sd0, 0);
        send_word(16'sd25736, 16'sd0, 16'sd16384, 16'sd0, 32'sd65536, 32'sd0, 32'sd65536, 1);
        send_word(-16'sd25736, 16'sd0, 16'sd16384, 16'sd0, 32'sd65536, 32'sd0, 32'sd0, 0);
        send_word(16'sd32767, 16'sd9459, 16'sd9459, 16'sd9459, 32'sd100, -32'sd100, 32'sd7, 2);
        send_word(-16'sd32768, -16'sd16384, 16'sd0, 16'sd0, 32'sd1, 32'sd2, 32'sd3, 0);
        send_word(16'sd12868, 16'sd0, 16'sd0, 16'sd16384,
            32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);
        send_word(16'sd6000, 16'sh8000, 16'sh8000, 16'sh8000,
            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 3);
        send_word(16'sd3000, 16'sd16384, 16'sd16384, 16'sd0, 32'sd65536, 32'sd65536, 32'sd0, 0);
        send_word(16'sd25737, 16'sd0, 16'sd0, -16'sd16384, -32'sd65536, 32'sd0, 32'sd0, 0);
        send_word(16'sd12867, 16'sd0, 16'sd0, 16'sd0, -32'sd1, 32'sd0, 32'sd1, 1);
        send_word(-16'sd14064, 16'sd16384, 16'sd0, 16'sd0,
            32'sd0, 32'sd65536, 32'sd0, 0);
        for (int n = 0; n < 2000; n++) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (n % 200 < 40) gap = 0;
            ax = rand_axis();
            ay = rand_axis();
            az = rand_axis();
            send_word(16'($urandom), ax, ay, az, rand_vec(), rand_vec(), rand_vec(), gap);
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/aav_pkg.sv
hdl/aav_cordic.sv
hdl/axis_angle_vector_rotate_top.sv
bench/aav_checker.sv
bench/tb_top.sv
